/* rtl/obd_rpm_speed_gear_tracker_assert.svh */
// ----------------------------------------------------------------------------
// OBD tracker assertion macros
// Same-cycle-implication and next-cycle-implication checks on clk, off in rst.
// ----------------------------------------------------------------------------
`ifndef OBD_RPM_SPEED_GEAR_TRACKER_ASSERT_SVH
`define OBD_RPM_SPEED_GEAR_TRACKER_ASSERT_SVH

// check that cons holds whenever ante holds
`define OBD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("obd tracker: implication check failed");

// check that cons holds in the cycle after ante
`define OBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("obd tracker: next-cycle check failed");

`endif

/* rtl/obdrsgt_pkg.sv */
// ----------------------------------------------------------------------------
// OBD rpm/speed/gear tracker package
// Character codes, register indexes, gear ratio table and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package obdrsgt_pkg;

  localparam int GEAR_COUNT    = 8;
  localparam int RATIO_ENTRIES = 8;

  localparam logic [13:0] ENGINE_RUN_RPM_RST    = 14'd600;
  localparam logic [7:0]  GEAR_MIN_SPEED_RST    = 8'd2;
  localparam logic [13:0] GEAR_MIN_RPM_RST      = 14'd500;
  localparam logic [15:0] GEAR_JUMP_HOLD_MS_RST = 16'd300;

  localparam logic [7:0] CH_PROMPT = 8'h3E;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;

  localparam logic [31:0] PAT_RPM   = 32'h3431_3043;  // "410C"
  localparam logic [31:0] PAT_SPEED = 32'h3431_3044;  // "410D"

  typedef enum logic [7:0] {
    CFG_ENGINE_RUN_RPM    = 8'd0,
    CFG_GEAR_MIN_SPEED    = 8'd1,
    CFG_GEAR_MIN_RPM      = 8'd2,
    CFG_GEAR_JUMP_HOLD_MS = 8'd3
  } cfg_index_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  function automatic logic [6:0] gear_ratio(input int idx);
    logic [6:0] r;
    case (idx)
      0:       r = 7'd95;
      1:       r = 7'd65;
      2:       r = 7'd48;
      3:       r = 7'd36;
      4:       r = 7'd28;
      5:       r = 7'd23;
      6:       r = 7'd19;
      default: r = 7'd16;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

  function automatic hex_digit_t hex_value(input logic [7:0] c);
    hex_digit_t r;
    r.ok    = 1'b0;
    r.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.ok    = 1'b1;
      r.value = c[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.ok    = 1'b1;
      r.value = 4'(c - 8'h37);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/obd_rpm_speed_gear_tracker.sv */
// ----------------------------------------------------------------------------
// OBD rpm/speed/gear tracker
// Parses adapter reply characters for rpm and speed replies and estimates gear.
// ----------------------------------------------------------------------------
// One character is taken per cycle while input is not stalled. Each non-blank
// line end yields one transaction on the output: the line end updates rpm,
// speed, peak and flags and fills the estimate stage, which runs up to eight
// parallel ratio comparators and loads the output register. Input stalls only
// while a finished estimate waits behind an output register that is still
// full. Blank lines and characters other than a line end yield nothing.
`default_nettype none

module obd_rpm_speed_gear_tracker
  import obdrsgt_pkg::*;
#(
  parameter int NUM_GEARS = GEAR_COUNT
)
(
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic [31:0] now_ms,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [15:0] cfg_data,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [13:0]      engine_rpm,
  output logic [7:0]       speed_kmh,
  output logic [3:0]       gear_estimate,
  output logic [13:0]      peak_rpm,
  output logic             ignition_on,
  output logic             engine_running,
  output logic             rpm_updated,
  output logic             speed_updated
);

  localparam int GEAR_LIMIT = (NUM_GEARS < RATIO_ENTRIES) ? NUM_GEARS : RATIO_ENTRIES;

  // configuration
  logic [13:0] engine_run_rpm;
  logic [7:0]  gear_min_speed;
  logic [13:0] gear_min_rpm;
  logic [15:0] gear_jump_hold_ms;

  // line state
  logic [31:0] recent_chars;
  logic        rpm_pattern_seen;
  logic [2:0]  rpm_digit_count;
  logic [15:0] rpm_digits;
  logic        rpm_digit_bad;
  logic        speed_pattern_seen;
  logic [1:0]  speed_digit_count;
  logic [7:0]  speed_digits;
  logic        speed_digit_bad;
  logic        line_has_content;

  // vehicle state
  logic [13:0] current_rpm;
  logic [13:0] max_rpm_seen;
  logic [7:0]  current_speed;
  logic [3:0]  current_gear;
  logic [31:0] last_gear_change_ms;
  logic        ignition_flag;
  logic        running_flag;

  // estimate stage
  logic        est_valid;
  logic [31:0] est_now;
  logic        est_rpm_ok;
  logic        est_spd_ok;

  logic        in_fire;
  logic        est_fire;
  logic        out_free;
  logic [7:0]  ch;
  logic        is_end;
  logic        is_space;
  logic        is_blankish;
  logic        rpm_ok;
  logic        spd_ok;
  logic [13:0] rpm_new;
  hex_digit_t  hd;
  logic [31:0] recent_next;

  logic [7:0]  spd_eff;
  logic [14:0] prod;
  logic [14:0] diff;
  logic [15:0] best_diff;
  logic [3:0]  best_gear;
  logic        force_zero;
  logic [3:0]  jump;
  logic [31:0] elapsed;
  logic        gear_take;
  logic [3:0]  gear_next;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign est_fire  = est_valid && out_free;
  assign in_ready  = !est_valid || out_free;
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    ch          = fold_upper(data_byte);
    is_end      = (data_byte == CH_PROMPT) || (data_byte == CH_CR) || (data_byte == CH_LF);
    is_space    = (data_byte == CH_SPACE);
    is_blankish = (data_byte == CH_TAB) || (data_byte == CH_VT) || (data_byte == CH_FF);
    hd          = hex_value(ch);
    recent_next = {recent_chars[23:0], ch};
    rpm_ok      = rpm_pattern_seen && (rpm_digit_count == 3'd4) && !rpm_digit_bad;
    spd_ok      = speed_pattern_seen && (speed_digit_count == 2'd2) && !speed_digit_bad;
    rpm_new     = rpm_digits[15:2];
  end

  // nearest ratio search, lowest gear wins ties
  always_comb begin
    spd_eff   = (current_speed == 8'd0) ? 8'd1 : current_speed;
    best_diff = 16'hFFFF;
    best_gear = 4'd0;
    prod      = 15'd0;
    diff      = 15'd0;
    for (int i = 0; i < GEAR_LIMIT; i++) begin
      prod = 15'(gear_ratio(i)) * 15'(spd_eff);
      diff = ({1'b0, current_rpm} > prod) ? ({1'b0, current_rpm} - prod)
                                          : (prod - {1'b0, current_rpm});
      if ({1'b0, diff} < best_diff) begin
        best_diff = {1'b0, diff};
        best_gear = 4'(i + 1);
      end
    end
    force_zero = (current_speed < gear_min_speed) || (current_rpm < gear_min_rpm);
    jump       = (best_gear > current_gear) ? (best_gear - current_gear)
                                            : (current_gear - best_gear);
    elapsed    = est_now - last_gear_change_ms;
    gear_take  = (best_gear != current_gear) &&
                 !((jump > 4'd1) && (elapsed < {16'd0, gear_jump_hold_ms}));
    gear_next  = force_zero ? 4'd0 : (gear_take ? best_gear : current_gear);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      engine_run_rpm    <= ENGINE_RUN_RPM_RST;
      gear_min_speed    <= GEAR_MIN_SPEED_RST;
      gear_min_rpm      <= GEAR_MIN_RPM_RST;
      gear_jump_hold_ms <= GEAR_JUMP_HOLD_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ENGINE_RUN_RPM:    engine_run_rpm    <= cfg_data[13:0];
        CFG_GEAR_MIN_SPEED:    gear_min_speed    <= cfg_data[7:0];
        CFG_GEAR_MIN_RPM:      gear_min_rpm      <= cfg_data[13:0];
        CFG_GEAR_JUMP_HOLD_MS: gear_jump_hold_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // character parsing and line end update
  always_ff @(posedge clk) begin
    if (rst) begin
      recent_chars       <= '0;
      rpm_pattern_seen   <= 1'b0;
      rpm_digit_count    <= '0;
      rpm_digits         <= '0;
      rpm_digit_bad      <= 1'b0;
      speed_pattern_seen <= 1'b0;
      speed_digit_count  <= '0;
      speed_digits       <= '0;
      speed_digit_bad    <= 1'b0;
      line_has_content   <= 1'b0;
      current_rpm        <= '0;
      max_rpm_seen       <= '0;
      current_speed      <= '0;
      ignition_flag      <= 1'b0;
      running_flag       <= 1'b0;
    end else if (in_fire) begin
      if (is_end) begin
        if (line_has_content) begin
          if (rpm_ok) begin
            current_rpm   <= rpm_new;
            ignition_flag <= 1'b1;
            running_flag  <= (rpm_new > engine_run_rpm);
            if (rpm_new > max_rpm_seen) begin
              max_rpm_seen <= rpm_new;
            end
          end
          if (spd_ok) begin
            current_speed <= speed_digits;
          end
        end
        recent_chars       <= '0;
        rpm_pattern_seen   <= 1'b0;
        rpm_digit_count    <= '0;
        rpm_digits         <= '0;
        rpm_digit_bad      <= 1'b0;
        speed_pattern_seen <= 1'b0;
        speed_digit_count  <= '0;
        speed_digits       <= '0;
        speed_digit_bad    <= 1'b0;
        line_has_content   <= 1'b0;
      end else if (!is_space) begin
        if (!is_blankish) begin
          line_has_content <= 1'b1;
        end
        if (rpm_pattern_seen && (rpm_digit_count < 3'd4)) begin
          if (hd.ok) begin
            rpm_digits <= {rpm_digits[11:0], hd.value};
          end else begin
            rpm_digit_bad <= 1'b1;
          end
          rpm_digit_count <= rpm_digit_count + 3'd1;
        end
        if (speed_pattern_seen && (speed_digit_count < 2'd2)) begin
          if (hd.ok) begin
            speed_digits <= {speed_digits[3:0], hd.value};
          end else begin
            speed_digit_bad <= 1'b1;
          end
          speed_digit_count <= speed_digit_count + 2'd1;
        end
        recent_chars <= recent_next;
        if (recent_next == PAT_RPM) begin
          rpm_pattern_seen <= 1'b1;
        end
        if (recent_next == PAT_SPEED) begin
          speed_pattern_seen <= 1'b1;
        end
      end
    end
  end

  // estimate stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      est_valid           <= 1'b0;
      out_valid           <= 1'b0;
      current_gear        <= '0;
      last_gear_change_ms <= '0;
    end else begin
      if (in_fire && is_end && line_has_content) begin
        est_valid <= 1'b1;
      end else if (est_fire) begin
        est_valid <= 1'b0;
      end
      if (est_fire) begin
        out_valid    <= 1'b1;
        current_gear <= gear_next;
        if (!force_zero && gear_take) begin
          last_gear_change_ms <= est_now;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_end) begin
      est_now    <= now_ms;
      est_rpm_ok <= rpm_ok;
      est_spd_ok <= spd_ok;
    end
    if (est_fire) begin
      engine_rpm     <= current_rpm;
      speed_kmh      <= current_speed;
      gear_estimate  <= gear_next;
      peak_rpm       <= max_rpm_seen;
      ignition_on    <= ignition_flag;
      engine_running <= running_flag;
      rpm_updated    <= est_rpm_ok;
      speed_updated  <= est_spd_ok;
    end
  end

`include "obd_rpm_speed_gear_tracker_assert.svh"

  `OBD_ASSERT_IMPL(a_peak_covers_rpm, out_valid, peak_rpm >= engine_rpm)
  `OBD_ASSERT_IMPL(a_no_ign_no_rpm, out_valid && !ignition_on,
                   engine_rpm == 14'd0 && !engine_running && !rpm_updated)
  `OBD_ASSERT_IMPL(a_gear_in_range, out_valid, gear_estimate <= 4'(GEAR_LIMIT))
  `OBD_ASSERT_NEXT(a_est_to_out, est_fire, out_valid && gear_estimate == current_gear)

endmodule

`default_nettype wire

/* tb/sv/obd_rpm_speed_gear_tracker_test.sv */
// ----------------------------------------------------------------------------
// OBD rpm/speed/gear tracker testbench
// Streams adapter reply lines into the tracker under random source and sink
// gaps and predicts every line report with a scoreboard. The stimulus covers
// rpm and speed replies with random content, broken and blank lines, chatter
// and raw noise, across several register settings.
// ----------------------------------------------------------------------------
module obd_rpm_speed_gear_tracker_test;
  import obdrsgt_pkg::*;

  localparam int          GEARS_IN_USE = (GEAR_COUNT < 8) ? GEAR_COUNT : 8;
  localparam int unsigned RATIO_TABLE [0:7] = '{95, 65, 48, 36, 28, 23, 19, 16};

  localparam logic [13:0] RUN_RPM_DEFAULT   = 14'd600;
  localparam logic [7:0]  MIN_SPEED_DEFAULT = 8'd2;
  localparam logic [13:0] MIN_RPM_DEFAULT   = 14'd500;
  localparam logic [15:0] HOLD_MS_DEFAULT   = 16'd300;

  typedef enum int {FLAW_NONE, FLAW_SHORT, FLAW_BAD} flaw_t;

  typedef struct packed {
    logic [13:0] engine_rpm;
    logic [7:0]  speed_kmh;
    logic [3:0]  gear;
    logic [13:0] peak;
    logic        ignition;
    logic        running;
    logic        rpm_upd;
    logic        speed_upd;
  } tracker_report_t;

  class gear_tracker_scoreboard;
    logic [13:0] run_rpm_cfg;
    logic [7:0]  min_speed_cfg;
    logic [13:0] min_rpm_cfg;
    logic [15:0] hold_ms_cfg;

    logic [31:0] last4;
    bit          rpm_armed;
    int          rpm_count;
    logic [15:0] rpm_acc;
    bit          rpm_bad;
    bit          spd_armed;
    int          spd_count;
    logic [7:0]  spd_acc;
    bit          spd_bad;
    bit          has_text;

    logic [13:0] rpm_now;
    logic [13:0] rpm_peak;
    logic [7:0]  speed_now;
    logic [3:0]  gear_now;
    logic [31:0] gear_change_ms;
    bit          ignition;
    bit          running;

    tracker_report_t expected_reports[$];
    int unsigned     errors;

    function new();
      run_rpm_cfg    = RUN_RPM_DEFAULT;
      min_speed_cfg  = MIN_SPEED_DEFAULT;
      min_rpm_cfg    = MIN_RPM_DEFAULT;
      hold_ms_cfg    = HOLD_MS_DEFAULT;
      rpm_now        = '0;
      rpm_peak       = '0;
      speed_now      = '0;
      gear_now       = '0;
      gear_change_ms = '0;
      ignition       = 1'b0;
      running        = 1'b0;
      errors         = 0;
      clear_line();
    endfunction

    function void clear_line();
      last4     = '0;
      rpm_armed = 1'b0;
      rpm_count = 0;
      rpm_acc   = '0;
      rpm_bad   = 1'b0;
      spd_armed = 1'b0;
      spd_count = 0;
      spd_acc   = '0;
      spd_bad   = 1'b0;
      has_text  = 1'b0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [15:0] val);
      case (idx)
        CFG_ENGINE_RUN_RPM:    run_rpm_cfg   = val[13:0];
        CFG_GEAR_MIN_SPEED:    min_speed_cfg = val[7:0];
        CFG_GEAR_MIN_RPM:      min_rpm_cfg   = val[13:0];
        CFG_GEAR_JUMP_HOLD_MS: hold_ms_cfg   = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function bit hex_nibble(logic [7:0] ch, output logic [3:0] v);
      v = 4'd0;
      if (ch >= "0" && ch <= "9") begin
        v = 4'(ch - "0");
        return 1'b1;
      end
      if (ch >= "A" && ch <= "F") begin
        v = 4'(ch - "A" + 8'd10);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void pick_gear(logic [31:0] t);
      int unsigned s, target, best, miss, prod, step;
      target = 0;
      best   = 32'hFFFF_FFFF;
      if (speed_now < min_speed_cfg || rpm_now < min_rpm_cfg) begin
        gear_now = 4'd0;
        return;
      end
      s = (speed_now == 8'd0) ? 1 : speed_now;
      for (int g = 1; g <= GEARS_IN_USE; g++) begin
        prod = RATIO_TABLE[g - 1] * s;
        miss = (rpm_now > prod) ? rpm_now - prod : prod - rpm_now;
        if (miss < best) begin
          best   = miss;
          target = g;
        end
      end
      if (target == gear_now) return;
      step = (target > gear_now) ? target - gear_now : gear_now - target;
      if (step > 1 && (t - gear_change_ms) < {16'd0, hold_ms_cfg}) return;
      gear_now       = 4'(target);
      gear_change_ms = t;
    endfunction

    function void take_char(logic [7:0] c, logic [31:0] t);
      logic [7:0]      ch;
      logic [3:0]      nib;
      logic [13:0]     rpm;
      bit              rpm_ok, spd_ok;
      tracker_report_t r;
      if (c == CH_PROMPT || c == CH_CR || c == CH_LF) begin
        if (has_text) begin
          rpm_ok = rpm_armed && rpm_count == 4 && !rpm_bad;
          spd_ok = spd_armed && spd_count == 2 && !spd_bad;
          if (rpm_ok) begin
            rpm = rpm_acc[15:2];
            if (rpm > rpm_peak) rpm_peak = rpm;
            rpm_now  = rpm;
            ignition = 1'b1;
            running  = rpm > run_rpm_cfg;
          end
          if (spd_ok) speed_now = spd_acc;
          pick_gear(t);
          r.engine_rpm = rpm_now;
          r.speed_kmh  = speed_now;
          r.gear       = gear_now;
          r.peak       = rpm_peak;
          r.ignition   = ignition;
          r.running    = running;
          r.rpm_upd    = rpm_ok;
          r.speed_upd  = spd_ok;
          expected_reports = {expected_reports, r};
        end
        clear_line();
        return;
      end
      if (c == CH_SPACE) return;
      if (c != CH_TAB && c != CH_VT && c != CH_FF) has_text = 1'b1;
      ch = (c >= "a" && c <= "z") ? c - 8'd32 : c;
      if (rpm_armed && rpm_count < 4) begin
        if (hex_nibble(ch, nib)) rpm_acc = {rpm_acc[11:0], nib};
        else rpm_bad = 1'b1;
        rpm_count++;
      end
      if (spd_armed && spd_count < 2) begin
        if (hex_nibble(ch, nib)) spd_acc = {spd_acc[3:0], nib};
        else spd_bad = 1'b1;
        spd_count++;
      end
      last4 = {last4[23:0], ch};
      if (!rpm_armed && last4 == "410C") rpm_armed = 1'b1;
      if (!spd_armed && last4 == "410D") spd_armed = 1'b1;
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_report(tracker_report_t got);
      tracker_report_t want;
      if (expected_reports.size() == 0) begin
        $error("unexpected report transaction: engine_rpm %0d speed_kmh %0d gear_estimate %0d",
               got.engine_rpm, got.speed_kmh, got.gear);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      check_field("engine_rpm", want.engine_rpm, got.engine_rpm);
      check_field("speed_kmh", want.speed_kmh, got.speed_kmh);
      check_field("gear_estimate", want.gear, got.gear);
      check_field("peak_rpm", want.peak, got.peak);
      check_field("ignition_on", want.ignition, got.ignition);
      check_field("engine_running", want.running, got.running);
      check_field("rpm_updated", want.rpm_upd, got.rpm_upd);
      check_field("speed_updated", want.speed_upd, got.speed_upd);
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic [31:0] now_ms    = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = CFG_ENGINE_RUN_RPM;
  logic [15:0] cfg_data  = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [13:0] engine_rpm;
  logic [7:0]  speed_kmh;
  logic [3:0]  gear_estimate;
  logic [13:0] peak_rpm;
  logic        ignition_on;
  logic        engine_running;
  logic        rpm_updated;
  logic        speed_updated;

  gear_tracker_scoreboard sb;
  logic [7:0]             line_buf[$];
  logic [31:0]            clock_ms   = '0;
  int unsigned            items_sent = 0;
  bit                     src_idle   = 1'b1;
  bit                     sink_idle  = 1'b1;

  obd_rpm_speed_gear_tracker i_dut (.*);

  always #5 clk = ~clk;

  initial begin
    #3_000_000;
    $display("** obd_rpm_speed_gear_tracker: FAILED **");
    $finish;
  end

  initial begin : report_sink
    tracker_report_t seen;
    int unsigned     gap;
    while (rst) @(posedge clk);
    forever begin
      gap = sink_idle ? $urandom_range(0, 12) : 0;
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      seen.engine_rpm = engine_rpm;
      seen.speed_kmh  = speed_kmh;
      seen.gear       = gear_estimate;
      seen.peak       = peak_rpm;
      seen.ignition   = ignition_on;
      seen.running    = engine_running;
      seen.rpm_upd    = rpm_updated;
      seen.speed_upd  = speed_updated;
      sb.check_report(seen);
    end
  end

  task automatic send_char(logic [7:0] c);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 12) : 0;
    clock_ms += $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= c;
    now_ms    <= clock_ms;
    do @(posedge clk); while (!in_ready);
    sb.take_char(c, clock_ms);
    if (c != CH_SPACE) items_sent++;
  endtask

  task automatic send_buffer();
    foreach (line_buf[i]) send_char(line_buf[i]);
    line_buf.delete();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  task automatic set_config(logic [13:0] run_rpm, logic [7:0] min_speed,
                            logic [13:0] min_rpm, logic [15:0] hold_ms);
    write_reg(CFG_ENGINE_RUN_RPM, {2'b00, run_rpm});
    write_reg(CFG_GEAR_MIN_SPEED, {8'h00, min_speed});
    write_reg(CFG_GEAR_MIN_RPM, {2'b00, min_rpm});
    write_reg(CFG_GEAR_JUMP_HOLD_MS, hold_ms);
    cfg_valid <= 1'b0;
  endtask

  function automatic void append_char(logic [7:0] c);
    line_buf = {line_buf, c};
  endfunction

  function automatic void add_text(string s, bit dressed);
    logic [7:0] ch;
    for (int i = 0; i < s.len(); i++) begin
      ch = s[i];
      if (dressed && ch >= "A" && ch <= "Z" && $urandom_range(0, 3) == 0) ch = ch + 8'd32;
      if (dressed && $urandom_range(0, 4) == 0) append_char(CH_SPACE);
      append_char(ch);
    end
  endfunction

  function automatic logic [7:0] bad_digit();
    case ($urandom_range(0, 7))
      0:       return "G";
      1:       return "z";
      2:       return ".";
      3:       return ":";
      4:       return CH_TAB;
      5:       return CH_VT;
      6:       return CH_FF;
      default: return "@";
    endcase
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_VT;
      default: return CH_FF;
    endcase
  endfunction

  function automatic logic [7:0] line_end();
    case ($urandom_range(0, 2))
      0:       return CH_CR;
      1:       return CH_LF;
      default: return CH_PROMPT;
    endcase
  endfunction

  function automatic string chatter();
    case ($urandom_range(0, 5))
      0:       return "010C";
      1:       return "010D";
      2:       return "NO DATA";
      3:       return "SEARCHING...";
      4:       return "41 0C";
      default: return "OK";
    endcase
  endfunction

  function automatic void add_reply(bit is_rpm, logic [15:0] v, flaw_t flaw, bit dressed);
    string d;
    d = is_rpm ? $sformatf("%04X", v) : $sformatf("%02X", v[7:0]);
    case (flaw)
      FLAW_SHORT: begin
        if ($urandom_range(0, 3) == 0) d = "";
        else d = d.substr(0, $urandom_range(0, d.len() - 2));
      end
      FLAW_BAD: d.putc($urandom_range(0, d.len() - 1), bad_digit());
      default: ;
    endcase
    add_text(is_rpm ? "410C" : "410D", dressed);
    add_text(d, dressed);
  endfunction

  // rpm near one gear's ratio times speed, now and then midway between two gears or a random raw value
  task automatic make_pair(output logic [15:0] raw, output logic [7:0] spd);
    int g, s, r;
    g = $urandom_range(0, 7);
    case ($urandom_range(0, 9))
      0:       s = $urandom_range(0, 3);
      1:       s = $urandom_range(141, 255);
      default: s = $urandom_range(4, 140);
    endcase
    if (g < 7 && $urandom_range(0, 7) == 0) r = (RATIO_TABLE[g] + RATIO_TABLE[g + 1]) * s / 2;
    else r = RATIO_TABLE[g] * s + int'($urandom_range(0, 60)) - 30;
    if (r < 0) r = 0;
    if (r > 16383) r = 16383;
    raw = 16'((r << 2) | $urandom_range(0, 3));
    if ($urandom_range(0, 9) == 0) raw = 16'($urandom_range(0, 65535));
    spd = 8'(s);
  endtask

  task automatic random_line();
    int          kind;
    logic [15:0] raw;
    logic [7:0]  spd;
    bit          dressed, rpm_first;
    if ($urandom_range(0, 9) == 0) begin
      src_idle  = $urandom_range(0, 2) != 0;
      sink_idle = $urandom_range(0, 2) != 0;
    end
    if ($urandom_range(0, 3) == 0) clock_ms += $urandom_range(0, 900);
    if ($urandom_range(0, 99) == 0) clock_ms = $urandom();
    make_pair(raw, spd);
    dressed = $urandom_range(0, 1);
    kind    = $urandom_range(0, 99);
    if (kind < 25) begin
      add_reply(1'b1, raw, FLAW_NONE, dressed);
    end else if (kind < 45) begin
      add_reply(1'b0, {8'h00, spd}, FLAW_NONE, dressed);
    end else if (kind < 70) begin
      rpm_first = $urandom_range(0, 1);
      add_reply(rpm_first, rpm_first ? raw : {8'h00, spd}, FLAW_NONE, dressed);
      add_reply(!rpm_first, rpm_first ? {8'h00, spd} : raw, FLAW_NONE, dressed);
    end else if (kind < 80) begin
      add_reply($urandom_range(0, 1), raw, flaw_t'($urandom_range(1, 2)), dressed);
    end else if (kind < 85) begin
      repeat ($urandom_range(0, 4)) append_char(blank_char());
    end else if (kind < 91) begin
      add_text(chatter(), 1'b0);
    end else begin
      repeat ($urandom_range(1, 10)) append_char(8'($urandom_range(0, 255)));
    end
    if (kind < 70 && $urandom_range(0, 5) == 0) begin
      make_pair(raw, spd);
      add_reply($urandom_range(0, 1), raw, FLAW_NONE, dressed);
    end
    append_char(line_end());
    if ($urandom_range(0, 3) == 0) append_char(line_end());
    send_buffer();
  endtask

  task automatic random_phase(int unsigned quota);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < quota) random_line();
    drain();
  endtask

  task automatic send_line(string body, logic [7:0] term);
    add_text(body, 1'b0);
    append_char(term);
    send_buffer();
  endtask

  task automatic directed_lines();
    send_line("410C0000", CH_CR);
    send_line("410CFFFF", CH_LF);
    send_line("410D00", CH_PROMPT);
    send_line("410DFF", CH_CR);
    send_line("41 0c 1a f8 41 0d 3c", CH_CR);
    send_line(" \t\013\014", CH_CR);
    send_line("", CH_LF);
    send_line("410C1\t23", CH_CR);
    send_line("410C12", CH_CR);
    send_line("410DG1", CH_PROMPT);
    send_line("410D10410D20", CH_CR);
    send_line("410D410C1234", CH_CR);
    send_line("410C410D", CH_LF);
    send_line("010C", CH_CR);
    send_line("410C0BB8410D1E", CH_LF);
    line_buf = '{8'h00, 8'hFF, 8'h7F, "z", "a", 8'h60, "{"};
    send_line("", CH_CR);
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    clock_ms = $urandom_range(0, 200);
    directed_lines();
    drain();

    random_phase(200);
    set_config(14'd0, 8'd0, 14'd0, 16'd0);
    random_phase(230);
    set_config(14'h3FFF, 8'hFF, 14'h3FFF, 16'hFFFF);
    random_phase(150);
    clock_ms = 32'hFFFF_FC00;
    set_config(14'($urandom_range(300, 3000)), 8'($urandom_range(0, 10)),
               14'($urandom_range(0, 1500)), 16'($urandom_range(0, 2000)));
    random_phase(250);
    set_config(14'($urandom_range(0, 16383)), 8'($urandom_range(0, 255)),
               14'($urandom_range(0, 16383)), 16'($urandom_range(0, 65535)));
    random_phase(250);
    set_config(14'd0, 8'd1, 14'd0, 16'hFFFF);
    random_phase(270);

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** obd_rpm_speed_gear_tracker: PASSED **");
    end else begin
      $display("** obd_rpm_speed_gear_tracker: FAILED **");
    end
    $finish;
  end

endmodule
